[design/conv2d_sliding_window_macros.svh]
// ----------------------------------------------------------------------------
// conv2d_sliding_window assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CONV2D_SLIDING_WINDOW_MACROS_SVH
`define CONV2D_SLIDING_WINDOW_MACROS_SVH
`ifndef SYNTHESIS
`define C2D_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define C2D_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define C2D_ASSERT(label, clk, rst_n, prop)
`define C2D_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

[design/c2d_pkg.sv]
// ----------------------------------------------------------------------------
// c2d_pkg
// Sizes, register codes and helper functions of the 2-D convolution block.
// ----------------------------------------------------------------------------
package c2d_pkg;
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int MAX_KERNEL  = 7;
	localparam int SAMPLE_BITS = 16;
	localparam int ROW_SPAN    = MAX_WIDTH + MAX_KERNEL - 1;
	localparam int COEF_COUNT  = MAX_KERNEL * MAX_KERNEL;
	localparam int LINE_ROWS   = MAX_KERNEL - 1;
	localparam int LINE_BITS   = LINE_ROWS * SAMPLE_BITS;
	localparam int DIM_BITS    = 11;
	localparam int KER_BITS    = 3;
	localparam int SHIFT_BITS  = 5;
	localparam int IDX_BITS    = 6;
	localparam int POS_BITS    = 10;
	localparam int RES_BITS    = 32;
	localparam int PROD_BITS   = 2 * SAMPLE_BITS;
	localparam int RSUM_BITS   = PROD_BITS + 3;
	localparam int ACC_BITS    = 48;
	localparam int REG_BITS    = 2;

	typedef enum logic [REG_BITS-1:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_KERNEL,
		REG_SHIFT
	} cfg_reg_t;

	function automatic logic [KER_BITS-1:0] eff_kernel(input logic [KER_BITS-1:0] k);
		logic [KER_BITS-1:0] t;
		t = (k == '0) ? KER_BITS'(1) : k;
		t = (t - KER_BITS'(1)) | KER_BITS'(1);
		if (t > KER_BITS'(MAX_KERNEL))
			t = KER_BITS'(MAX_KERNEL);
		return t;
	endfunction

	function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
		input logic [DIM_BITS-1:0] hi);
		if (v == '0)
			return DIM_BITS'(1);
		return (v > hi) ? hi : v;
	endfunction
endpackage

[design/c2d_ram.sv]
// ----------------------------------------------------------------------------
// c2d_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module c2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule

[design/conv2d_sliding_window.sv]
// ----------------------------------------------------------------------------
// conv2d_sliding_window: streaming KxK correlation over a padded image.
// Samples pass stages s1 to s5 and the output register; one word per cycle unless out_ready stalls.
// The line store is one read and one write of the row RAM per sample.
// Reset restores the register defaults and the frame position; no clearing pass.
// ----------------------------------------------------------------------------
`include "conv2d_sliding_window_macros.svh"

module conv2d_sliding_window (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [c2d_pkg::REG_BITS-1:0]            cfg_index,
	input  logic [c2d_pkg::DIM_BITS-1:0]            cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    kind,
	input  logic [c2d_pkg::IDX_BITS-1:0]            coef_index,
	input  logic signed [c2d_pkg::SAMPLE_BITS-1:0]  coef_value,
	input  logic signed [c2d_pkg::SAMPLE_BITS-1:0]  pixel_value,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [c2d_pkg::RES_BITS-1:0]     result,
	output logic [c2d_pkg::POS_BITS-1:0]            out_row,
	output logic [c2d_pkg::POS_BITS-1:0]            out_col,
	output logic                                    frame_last,
	output logic                                    saturated
);
	import c2d_pkg::*;

	logic [DIM_BITS-1:0]   width_q, height_q;
	logic [KER_BITS-1:0]   ksize_q;
	logic [SHIFT_BITS-1:0] shift_q;
	logic [DIM_BITS-1:0]   row_q, col_q;
	logic [KER_BITS-1:0]   k_eff;
	logic [DIM_BITS-1:0]   w_eff, h_eff, pw, rows_n, k_ext, c_cur, r_cur;
	logic                  adv, acc_in, col_end, frame_end, emit;

	logic                       v_s1, kind_s1, emit_s1, last_s1;
	logic [SAMPLE_BITS-1:0]     pix_s1, cval_s1;
	logic [IDX_BITS-1:0]        cidx_s1;
	logic [DIM_BITS-1:0]        c_s1;
	logic [POS_BITS-1:0]        row_s1, colp_s1;
	logic [LINE_BITS-1:0]       line_rd, line_wr;
	logic signed [SAMPLE_BITS-1:0] colv [MAX_KERNEL];

	logic signed [SAMPLE_BITS-1:0] win_q  [MAX_KERNEL][MAX_KERNEL];
	logic signed [SAMPLE_BITS-1:0] coef_q [COEF_COUNT];
	logic signed [SAMPLE_BITS-1:0] csel   [MAX_KERNEL][MAX_KERNEL];

	logic                   v_s2, last_s2, v_s3, last_s3, v_s4, last_s4, v_s5, last_s5;
	logic [POS_BITS-1:0]    row_s2, col_s2, row_s3, col_s3, row_s4, col_s4, row_s5, col_s5;
	logic signed [PROD_BITS-1:0] prod_s3 [MAX_KERNEL][MAX_KERNEL];
	logic signed [RSUM_BITS-1:0] rsum_s4 [MAX_KERNEL];
	logic signed [ACC_BITS-1:0]  acc_s5, shifted;
	logic                   fits;

	always_comb begin
		k_eff     = eff_kernel(ksize_q);
		k_ext     = DIM_BITS'(k_eff);
		w_eff     = clamp_dim(width_q, DIM_BITS'(MAX_WIDTH));
		h_eff     = clamp_dim(height_q, DIM_BITS'(MAX_HEIGHT));
		pw        = w_eff + k_ext - DIM_BITS'(1);
		rows_n    = h_eff + k_ext - DIM_BITS'(1);
		c_cur     = (col_q >= pw) ? '0 : col_q;
		r_cur     = (row_q >= rows_n) ? '0 : row_q;
		col_end   = (c_cur + DIM_BITS'(1)) == pw;
		frame_end = ((r_cur + DIM_BITS'(1)) == rows_n) && col_end;
		emit      = ((r_cur + DIM_BITS'(1)) >= k_ext) && ((c_cur + DIM_BITS'(1)) >= k_ext);
	end

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;
	assign acc_in   = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_BITS'(MAX_WIDTH);
			height_q <= DIM_BITS'(MAX_HEIGHT);
			ksize_q  <= KER_BITS'(3);
			shift_q  <= SHIFT_BITS'(14);
			row_q    <= '0;
			col_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_KERNEL: ksize_q  <= cfg_data[KER_BITS-1:0];
				REG_SHIFT:  shift_q  <= cfg_data[SHIFT_BITS-1:0];
			endcase
			row_q <= '0;
			col_q <= '0;
		end else if (acc_in && kind) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : r_cur + DIM_BITS'(1);
			end else begin
				col_q <= c_cur + DIM_BITS'(1);
				row_q <= r_cur;
			end
		end
	end

	c2d_ram #(.WIDTH(LINE_BITS), .DEPTH(ROW_SPAN)) u_line_ram (
		.clk   (clk),
		.we    (adv && v_s1 && kind_s1),
		.waddr (c_s1),
		.wdata (line_wr),
		.re    (acc_in && kind),
		.raddr (c_cur),
		.rdata (line_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc_in;
			v_s2 <= v_s1 && kind_s1 && emit_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			out_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= kind;
			pix_s1  <= pixel_value;
			cval_s1 <= coef_value;
			cidx_s1 <= coef_index;
			c_s1    <= c_cur;
			emit_s1 <= emit;
			last_s1 <= frame_end;
			row_s1  <= POS_BITS'(r_cur + DIM_BITS'(1) - k_ext);
			colp_s1 <= POS_BITS'(c_cur + DIM_BITS'(1) - k_ext);
		end
	end

	always_comb begin
		for (int ky = 0; ky < MAX_KERNEL; ky++) begin
			if (ky + 1 < int'(k_eff))
				colv[ky] = line_rd[ky*SAMPLE_BITS +: SAMPLE_BITS];
			else
				colv[ky] = pix_s1;
		end
		for (int ky = 0; ky < LINE_ROWS; ky++)
			line_wr[ky*SAMPLE_BITS +: SAMPLE_BITS] = colv[ky+1];
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			if (kind_s1) begin
				for (int ky = 0; ky < MAX_KERNEL; ky++) begin
					for (int kx = 0; kx < MAX_KERNEL; kx++) begin
						if (kx + 1 < int'(k_eff))
							win_q[ky][kx] <= win_q[ky][kx+1];
						else if (kx + 1 == int'(k_eff))
							win_q[ky][kx] <= colv[ky];
					end
				end
			end else if (int'(cidx_s1) < COEF_COUNT) begin
				coef_q[cidx_s1] <= cval_s1;
			end
		end
	end

	always_comb begin
		for (int ky = 0; ky < MAX_KERNEL; ky++) begin
			for (int kx = 0; kx < MAX_KERNEL; kx++) begin
				csel[ky][kx] = '0;
				if (ky < int'(k_eff) && kx < int'(k_eff)) begin
					case (k_eff)
						KER_BITS'(1): csel[ky][kx] = coef_q[ky*1 + kx];
						KER_BITS'(3): csel[ky][kx] = coef_q[ky*3 + kx];
						KER_BITS'(5): csel[ky][kx] = coef_q[ky*5 + kx];
						KER_BITS'(7): csel[ky][kx] = coef_q[ky*7 + kx];
						default:      csel[ky][kx] = '0;
					endcase
				end
			end
		end
	end

	always_comb begin
		shifted = acc_s5 >>> shift_q;
		fits    = (&shifted[ACC_BITS-1:RES_BITS-1]) || !(|shifted[ACC_BITS-1:RES_BITS-1]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s2  <= row_s1;
			col_s2  <= colp_s1;
			last_s2 <= last_s1;
			row_s3  <= row_s2;
			col_s3  <= col_s2;
			last_s3 <= last_s2;
			row_s4  <= row_s3;
			col_s4  <= col_s3;
			last_s4 <= last_s3;
			row_s5  <= row_s4;
			col_s5  <= col_s4;
			last_s5 <= last_s4;
			for (int ky = 0; ky < MAX_KERNEL; ky++)
				for (int kx = 0; kx < MAX_KERNEL; kx++)
					if (ky < int'(k_eff) && kx < int'(k_eff))
						prod_s3[ky][kx] <= win_q[ky][kx] * csel[ky][kx];
					else
						prod_s3[ky][kx] <= '0;
			for (int ky = 0; ky < MAX_KERNEL; ky++) begin
				rsum_s4[ky] <= RSUM_BITS'(prod_s3[ky][0]) + RSUM_BITS'(prod_s3[ky][1])
					+ RSUM_BITS'(prod_s3[ky][2]) + RSUM_BITS'(prod_s3[ky][3])
					+ RSUM_BITS'(prod_s3[ky][4]) + RSUM_BITS'(prod_s3[ky][5])
					+ RSUM_BITS'(prod_s3[ky][6]);
			end
			acc_s5 <= ACC_BITS'(rsum_s4[0]) + ACC_BITS'(rsum_s4[1]) + ACC_BITS'(rsum_s4[2])
				+ ACC_BITS'(rsum_s4[3]) + ACC_BITS'(rsum_s4[4]) + ACC_BITS'(rsum_s4[5])
				+ ACC_BITS'(rsum_s4[6]);
			out_row    <= row_s5;
			out_col    <= col_s5;
			frame_last <= last_s5;
			saturated  <= !fits;
			if (fits)
				result <= shifted[RES_BITS-1:0];
			else if (shifted[ACC_BITS-1])
				result <= {1'b1, {(RES_BITS-1){1'b0}}};
			else
				result <= {1'b0, {(RES_BITS-1){1'b1}}};
		end
	end

	`C2D_ASSERT(a_last_pos, clk, arst_n, out_valid && frame_last |-> (out_row == POS_BITS'(h_eff - DIM_BITS'(1))) && (out_col == POS_BITS'(w_eff - DIM_BITS'(1))))
	`C2D_ASSERT(a_sat_clip, clk, arst_n, out_valid && saturated |-> (result == {1'b1, {(RES_BITS-1){1'b0}}}) || (result == {1'b0, {(RES_BITS-1){1'b1}}}))
	`C2D_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(result))
endmodule

[test/conv2d_sliding_window_tb.sv]
// ----------------------------------------------------------------------------
// conv2d_sliding_window testbench
// Streams coefficient loads and padded frames of many sizes, kernel sides and
// shifts through the block with random gaps on both sides, and checks every
// output word against an in-bench model of the sliding-window correlation.
// ----------------------------------------------------------------------------
module conv2d_sliding_window_tb;
	import c2d_pkg::*;

	typedef struct {
		logic signed [RES_BITS-1:0] sum;
		logic [POS_BITS-1:0]        row;
		logic [POS_BITS-1:0]        col;
		logic                       last;
		logic                       clip;
	} window_sum_t;

	class window_scoreboard;
		int unsigned width_reg, height_reg, ksize_reg, shift_reg;
		logic signed [SAMPLE_BITS-1:0] line_mem [LINE_ROWS][ROW_SPAN];
		logic signed [SAMPLE_BITS-1:0] win [COEF_COUNT];
		logic signed [SAMPLE_BITS-1:0] coefs [COEF_COUNT];
		int unsigned row_pos, col_pos;
		window_sum_t pending_sums [$];
		int errors;
		int words_checked;
		int saturations;
		int frame_ends;

		function void clear();
			width_reg = 1024;
			height_reg = 1024;
			ksize_reg = 3;
			shift_reg = 14;
			row_pos = 0;
			col_pos = 0;
			foreach (win[i]) win[i] = '0;
			foreach (coefs[i]) coefs[i] = '0;
			foreach (line_mem[i, j]) line_mem[i][j] = '0;
		endfunction

		function void set_reg(cfg_reg_t idx, int unsigned val);
			case (idx)
				REG_WIDTH:  width_reg = val & 'h7FF;
				REG_HEIGHT: height_reg = val & 'h7FF;
				REG_KERNEL: ksize_reg = val & 'h7;
				REG_SHIFT:  shift_reg = val & 'h1F;
			endcase
			row_pos = 0;
			col_pos = 0;
		endfunction

		function int unsigned side();
			int unsigned k;
			k = (ksize_reg == 0) ? 1 : ksize_reg;
			k = (k - 1) | 1;
			return (k > MAX_KERNEL) ? MAX_KERNEL : k;
		endfunction

		function int unsigned dim(int unsigned v, int unsigned hi);
			if (v == 0)
				return 1;
			return (v > hi) ? hi : v;
		endfunction

		function void note_input(logic knd, logic [IDX_BITS-1:0] idx,
			logic signed [SAMPLE_BITS-1:0] cval, logic signed [SAMPLE_BITS-1:0] pix);
			int unsigned k, pw, rows, c, r;
			logic signed [SAMPLE_BITS-1:0] colv [MAX_KERNEL];
			longint signed acc, shifted;
			window_sum_t e;
			bit last;
			if (!knd) begin
				if (idx < COEF_COUNT)
					coefs[idx] = cval;
				return;
			end
			k = side();
			pw = dim(width_reg, MAX_WIDTH) + k - 1;
			rows = dim(height_reg, MAX_HEIGHT) + k - 1;
			c = (col_pos >= pw) ? 0 : col_pos;
			r = (row_pos >= rows) ? 0 : row_pos;
			for (int ky = 0; ky + 1 < k; ky++)
				colv[ky] = line_mem[ky][c];
			colv[k-1] = pix;
			for (int ky = 0; ky + 1 < k; ky++)
				line_mem[ky][c] = colv[ky+1];
			for (int ky = 0; ky < k; ky++) begin
				for (int kx = 0; kx + 1 < k; kx++)
					win[ky*MAX_KERNEL+kx] = win[ky*MAX_KERNEL+kx+1];
				win[ky*MAX_KERNEL+k-1] = colv[ky];
			end
			last = (r + 1 == rows) && (c + 1 == pw);
			if (c + 1 == pw) begin
				col_pos = 0;
				row_pos = last ? 0 : r + 1;
			end else begin
				col_pos = c + 1;
				row_pos = r;
			end
			if (r + 1 < k || c + 1 < k)
				return;
			acc = 0;
			for (int ky = 0; ky < k; ky++)
				for (int kx = 0; kx < k; kx++)
					acc += longint'(win[ky*MAX_KERNEL+kx]) * longint'(coefs[ky*k+kx]);
			shifted = acc >>> shift_reg;
			e.clip = 1'b0;
			if (shifted > 64'sd2147483647) begin
				shifted = 64'sd2147483647;
				e.clip = 1'b1;
			end else if (shifted < -64'sd2147483648) begin
				shifted = -64'sd2147483648;
				e.clip = 1'b1;
			end
			e.sum = shifted[RES_BITS-1:0];
			e.row = POS_BITS'(r + 1 - k);
			e.col = POS_BITS'(c + 1 - k);
			e.last = last;
			pending_sums.push_back(e);
		endfunction

		function void check(logic signed [RES_BITS-1:0] sum, logic [POS_BITS-1:0] row,
			logic [POS_BITS-1:0] col, logic last, logic clip);
			window_sum_t e;
			if (pending_sums.size() == 0) begin
				$error("unexpected output word: result %0d row %0d col %0d", sum, row, col);
				errors++;
				return;
			end
			e = pending_sums.pop_front();
			words_checked++;
			if (clip) saturations++;
			if (last) frame_ends++;
			if (sum !== e.sum) begin
				$error("result: expected %0d, got %0d", e.sum, sum);
				errors++;
			end
			if (row !== e.row) begin
				$error("out_row: expected %0d, got %0d", e.row, row);
				errors++;
			end
			if (col !== e.col) begin
				$error("out_col: expected %0d, got %0d", e.col, col);
				errors++;
			end
			if (last !== e.last) begin
				$error("frame_last: expected %0b, got %0b", e.last, last);
				errors++;
			end
			if (clip !== e.clip) begin
				$error("saturated: expected %0b, got %0b", e.clip, clip);
				errors++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [REG_BITS-1:0]           cfg_index;
	logic [DIM_BITS-1:0]           cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic                          kind;
	logic [IDX_BITS-1:0]           coef_index;
	logic signed [SAMPLE_BITS-1:0] coef_value;
	logic signed [SAMPLE_BITS-1:0] pixel_value;
	logic                          out_valid;
	logic                          out_ready;
	logic signed [RES_BITS-1:0]    result;
	logic [POS_BITS-1:0]           out_row;
	logic [POS_BITS-1:0]           out_col;
	logic                          frame_last;
	logic                          saturated;

	window_scoreboard sb;
	bit calm;
	int pixels_sent;
	int phases;

	conv2d_sliding_window u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .coef_index(coef_index), .coef_value(coef_value),
		.pixel_value(pixel_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.result(result), .out_row(out_row), .out_col(out_col),
		.frame_last(frame_last), .saturated(saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check(result, out_row, out_col, frame_last, saturated);

	initial begin
		int n;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = calm ? 0 : $urandom_range(0, 10);
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_word(logic knd, logic [IDX_BITS-1:0] idx,
		logic signed [SAMPLE_BITS-1:0] cval, logic signed [SAMPLE_BITS-1:0] pix);
		int n;
		n = calm ? 0 : $urandom_range(0, 10);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= knd;
		coef_index <= idx;
		coef_value <= cval;
		pixel_value <= pix;
		do @(posedge clk); while (!in_ready);
		sb.note_input(knd, idx, cval, pix);
		if (knd)
			pixels_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_sums.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= DIM_BITS'(val);
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic setup(int unsigned w, int unsigned h, int unsigned k, int unsigned sh);
		drain();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_KERNEL, k);
		write_reg(REG_SHIFT, sh);
		cfg_we <= 1'b0;
		phases++;
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	task automatic send_frame(int unsigned count);
		for (int i = 0; i < count; i++)
			if ($urandom_range(0, 19) == 0)
				send_word(1'b0, IDX_BITS'($urandom), rand_sample(), rand_sample());
			else
				send_word(1'b1, IDX_BITS'($urandom), rand_sample(), rand_sample());
	endtask

	initial begin
		int unsigned w, h, k, pw, rows;
		sb = new();
		sb.clear();
		calm = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		kind <= 1'b0;
		coef_index <= '0;
		coef_value <= '0;
		pixel_value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every coefficient is given a value before the first sample.
		for (int i = 0; i < COEF_COUNT; i++)
			send_word(1'b0, IDX_BITS'(i), (i == 0) ? 16'sh7FFF : rand_sample(), '0);
		send_word(1'b0, IDX_BITS'(63), 16'sh8000, 16'sh7FFF);

		// Reset defaults, then a zero kernel side taken as one with no shift.
		send_frame(5);
		setup(3, 2, 0, 0);
		send_word(1'b1, '0, '0, 16'sh7FFF);
		send_word(1'b1, '0, '0, 16'sh8000);
		send_word(1'b1, '0, '0, 16'sh0001);
		send_word(1'b1, '0, '0, 16'shFFFF);
		send_word(1'b0, '0, 16'sh8000, '0);
		send_word(1'b1, '0, '0, 16'sh8000);
		send_word(1'b1, '0, '0, 16'sh7FFF);
		// Even side taken as the odd one below, with the shift at its top.
		setup(0, 1, 4, 31);
		send_frame(9);
		// Out-of-range width and height, clamped, with the opening part of each frame; then side seven.
		setup(2047, 1, 1, 14);
		send_frame(120);
		setup(1, 2047, 0, 3);
		send_frame(120);
		setup(1, 1, 7, 0);
		send_frame(49);

		while (pixels_sent < 560) begin
			calm = ($urandom_range(0, 3) == 0);
			w = $urandom_range(1, 8);
			h = $urandom_range(1, 4);
			k = $urandom_range(0, 7);
			setup(w, h, k, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 31));
			k = sb.side();
			pw = w + k - 1;
			rows = h + k - 1;
			repeat ($urandom_range(1, 2)) begin
				if ($urandom_range(0, 4) == 0)
					send_frame($urandom_range(1, pw * rows));
				else
					send_frame(pw * rows);
			end
		end
		calm = 1'b0;
		drain();
		$display("Checked %0d output words over %0d settings and %0d samples;",
			sb.words_checked, phases, pixels_sent);
		$display("%0d were saturated and %0d closed a frame.", sb.saturations, sb.frame_ends);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
